// ----- src/brl_pkg.sv -----
// Shared types and constants for the byte rate limiter.
// Holds field widths, operation and status codes, and the constant-multiply term table.
// No dependencies.
`default_nettype none

package brl_pkg;

    localparam int RATE_W     = 41;   // signed rate register
    localparam int DIV_W      = 40;   // magnitude of a non-negative rate
    localparam int BYTES_W    = 40;
    localparam int TMO_W      = 32;
    localparam int TMO_US_W   = 42;   // timeout_ms * 1000
    localparam int OUT_TIME_W = 62;   // width of the time ports
    localparam int PROD_W     = 60;   // xfer_bytes * 1,000,000

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 64;
    localparam logic [PADDR_W-4:0] REG_RATE = '0;

    typedef logic [1:0] t_func;
    typedef logic [1:0] t_status;

    localparam t_func FN_CONSUME = 2'd0;
    localparam t_func FN_CHECK   = 2'd1;
    localparam t_func FN_ACQUIRE = 2'd2;

    localparam t_status ST_GRANTED  = 2'd0;
    localparam t_status ST_WAITING  = 2'd1;
    localparam t_status ST_TIMEOUT  = 2'd2;
    localparam t_status ST_CONSUMED = 2'd3;

    // 1,000,000 = 2^20 - 2^16 + 2^14 + 2^9 + 2^6. The accumulator starts at
    // bytes << MUL_TOP_SHIFT and adds or subtracts one remaining term per cycle.
    localparam int MUL_TOP_SHIFT = 20;
    localparam int MUL_TERMS     = 4;
    localparam int TERM_W        = 2;
    localparam logic [4:0] MUL_SHIFT [MUL_TERMS] = '{5'd16, 5'd14, 5'd9, 5'd6};
    localparam logic [MUL_TERMS-1:0] MUL_SUB = 4'b0001;   // bit i set: subtract term i

    localparam int CNT_W = 6;   // counts the quotient bits of the divider

endpackage

`default_nettype wire

// ----- src/byte_rate_limiter_unit.sv -----
// Byte rate limiter: virtual-clock throttle with consume, check and acquire-poll operations.
// Uses brl_pkg for widths and codes; the consume delay comes from a bit-serial divider.
// Check and acquire poll go from evaluate straight to result load; a consume with a
// positive rate runs evaluate, 4 multiply steps, 60 divide steps at one quotient bit per
// cycle, saturate and result load.
// One item is in work at a time: a new item is taken only once the previous result is
// loaded and the unit is back in idle. Reset (synchronous, active low) sets the
// rate to -1 (throttling off), clears the next-allowed time, deadline and pending flag.
`default_nettype none

module byte_rate_limiter_unit #(
    parameter int TIME_BITS = 62
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,

    input  wire logic                                i_in_valid,
    output      logic                                o_in_stall,
    input  wire logic [1:0]                          i_func,
    input  wire logic [brl_pkg::OUT_TIME_W-1:0]      i_now_us,
    input  wire logic [brl_pkg::BYTES_W-1:0]         i_xfer_bytes,
    input  wire logic [brl_pkg::TMO_W-1:0]           i_timeout_ms,

    output      logic                                o_out_valid,
    input  wire logic                                i_out_stall,
    output      logic [1:0]                          o_status,
    output      logic [brl_pkg::OUT_TIME_W-1:0]      o_next_allowed_us,

    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [brl_pkg::PADDR_W-1:0]         paddr,
    input  wire logic [brl_pkg::PDATA_W-1:0]         pwdata,
    output      logic [brl_pkg::PDATA_W-1:0]         prdata,
    output      logic                                pready
);

    localparam int TB   = TIME_BITS;
    localparam int DL_W = ((TB > brl_pkg::TMO_US_W) ? TB : brl_pkg::TMO_US_W) + 1;
    localparam int SW   = (TB > brl_pkg::PROD_W) ? TB : brl_pkg::PROD_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EVAL   = 3'd1;
    localparam logic [2:0] S_MUL    = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_SAT    = 3'd4;
    localparam logic [2:0] S_RESULT = 3'd5;

    logic [2:0]                        r_state, n_state;
    brl_pkg::t_func                    r_func;
    logic [TB-1:0]                     r_now;
    logic [brl_pkg::BYTES_W-1:0]       r_bytes;
    logic [brl_pkg::TMO_W-1:0]         r_tmo;
    logic [brl_pkg::RATE_W-1:0]        r_rate;
    logic [TB-1:0]                     r_next, n_next;
    logic [DL_W-1:0]                   r_deadline, n_deadline;
    logic                              r_pending, n_pending;
    logic [TB-1:0]                     r_base, n_base;
    logic [brl_pkg::PROD_W-1:0]        r_acc, n_acc;
    logic [brl_pkg::DIV_W-1:0]         r_rem, n_rem;
    logic [brl_pkg::CNT_W-1:0]         r_cnt, n_cnt;
    logic [brl_pkg::TERM_W-1:0]        r_term, n_term;
    brl_pkg::t_status                  r_status, n_status;
    logic                              r_out_valid, n_out_valid;
    brl_pkg::t_status                  r_out_status, n_out_status;
    logic [brl_pkg::OUT_TIME_W-1:0]    r_out_next, n_out_next;

    logic                              in_accept;
    logic                              cfg_write;
    logic                              throttle_off;
    logic                              now_gt_next;
    logic [brl_pkg::TMO_US_W-1:0]      tmo_x;
    logic [brl_pkg::TMO_US_W-1:0]      tmo_us;
    logic [DL_W-1:0]                   new_deadline;
    logic [DL_W-1:0]                   eff_deadline;
    logic                              now_ge_deadline;
    logic [brl_pkg::PROD_W-1:0]        mul_term;
    logic [brl_pkg::DIV_W:0]           div_trial;
    logic [brl_pkg::DIV_W:0]           div_divisor;
    logic [brl_pkg::DIV_W:0]           div_diff;
    logic                              div_ge;
    logic [TB-1:0]                     sat_gap;
    logic                              sat_hit;
    logic [TB-1:0]                     sat_sum;

    assign in_accept    = i_in_valid && !o_in_stall;
    assign cfg_write    = psel && penable && pwrite && pready;
    assign throttle_off = r_rate[brl_pkg::RATE_W-1];

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_status          = r_out_status;
    assign o_next_allowed_us = r_out_next;

    assign pready = 1'b1;
    assign prdata = (paddr[brl_pkg::PADDR_W-1:3] == brl_pkg::REG_RATE)
                  ? brl_pkg::PDATA_W'($signed(r_rate)) : '0;

    // Acquire deadline: timeout_ms * 1000 as 1024 - 16 - 8.
    assign tmo_x           = brl_pkg::TMO_US_W'(r_tmo);
    assign tmo_us          = (tmo_x << 10) - (tmo_x << 4) - (tmo_x << 3);
    assign new_deadline    = DL_W'(r_now) + DL_W'(tmo_us);
    assign eff_deadline    = r_pending ? r_deadline : new_deadline;
    assign now_ge_deadline = (DL_W'(r_now) >= eff_deadline);
    assign now_gt_next     = (r_now > r_next);

    assign mul_term = brl_pkg::PROD_W'(r_bytes) << brl_pkg::MUL_SHIFT[r_term];

    // Restoring division, one quotient bit per cycle shifted into the accumulator.
    assign div_trial   = {r_rem, r_acc[brl_pkg::PROD_W-1]};
    assign div_divisor = {1'b0, r_rate[brl_pkg::DIV_W-1:0]};
    assign div_diff    = div_trial - div_divisor;
    assign div_ge      = (div_trial >= div_divisor);

    // The room left below the all-ones time is simply the inverted base.
    assign sat_gap = ~r_base;
    assign sat_hit = (SW'(r_acc) >= SW'(sat_gap));
    assign sat_sum = r_base + TB'(r_acc);

    always_comb begin
        n_state      = r_state;
        n_next       = r_next;
        n_deadline   = r_deadline;
        n_pending    = r_pending;
        n_base       = r_base;
        n_acc        = r_acc;
        n_rem        = r_rem;
        n_cnt        = r_cnt;
        n_term       = r_term;
        n_status     = r_status;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_status = r_out_status;
        n_out_next   = r_out_next;

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = S_RESULT;
                case (r_func)
                    brl_pkg::FN_CONSUME: begin
                        n_status = brl_pkg::ST_CONSUMED;
                        if (!throttle_off) begin
                            if (r_rate == '0) begin
                                n_next = '1;
                            end else begin
                                n_base  = now_gt_next ? r_now : r_next;
                                n_acc   = brl_pkg::PROD_W'(r_bytes) << brl_pkg::MUL_TOP_SHIFT;
                                n_rem   = '0;
                                n_term  = '0;
                                n_cnt   = brl_pkg::CNT_W'(brl_pkg::PROD_W - 1);
                                n_state = S_MUL;
                            end
                        end
                    end
                    brl_pkg::FN_ACQUIRE: begin
                        if (throttle_off) begin
                            n_pending = 1'b0;
                            n_status  = brl_pkg::ST_GRANTED;
                        end else begin
                            if (!r_pending) begin
                                n_deadline = new_deadline;
                            end
                            if (now_gt_next) begin
                                n_pending = 1'b0;
                                n_status  = brl_pkg::ST_GRANTED;
                            end else if (now_ge_deadline) begin
                                n_pending = 1'b0;
                                n_status  = brl_pkg::ST_TIMEOUT;
                            end else begin
                                n_pending = 1'b1;
                                n_status  = brl_pkg::ST_WAITING;
                            end
                        end
                    end
                    default: begin
                        // Check, and the unused code that acts as check.
                        n_status = (throttle_off || now_gt_next)
                                 ? brl_pkg::ST_GRANTED : brl_pkg::ST_WAITING;
                    end
                endcase
            end
            S_MUL: begin
                n_acc  = brl_pkg::MUL_SUB[r_term] ? (r_acc - mul_term) : (r_acc + mul_term);
                n_term = r_term + 1'b1;
                if (r_term == brl_pkg::TERM_W'(brl_pkg::MUL_TERMS - 1)) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_rem = div_ge ? div_diff[brl_pkg::DIV_W-1:0] : div_trial[brl_pkg::DIV_W-1:0];
                n_acc = {r_acc[brl_pkg::PROD_W-2:0], div_ge};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_SAT;
                end
            end
            S_SAT: begin
                n_next  = sat_hit ? '1 : sat_sum;
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_next   = brl_pkg::OUT_TIME_W'(r_next);
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rate      <= '1;
            r_next      <= '0;
            r_deadline  <= '0;
            r_pending   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_next      <= n_next;
            r_deadline  <= n_deadline;
            r_pending   <= n_pending;
            r_out_valid <= n_out_valid;
            if (cfg_write && (paddr[brl_pkg::PADDR_W-1:3] == brl_pkg::REG_RATE)) begin
                r_rate <= pwdata[brl_pkg::RATE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_func  <= i_func;
            r_now   <= TB'(i_now_us);
            r_bytes <= i_xfer_bytes;
            r_tmo   <= i_timeout_ms;
        end
        r_base       <= n_base;
        r_acc        <= n_acc;
        r_rem        <= n_rem;
        r_cnt        <= n_cnt;
        r_term       <= n_term;
        r_status     <= n_status;
        r_out_status <= n_out_status;
        r_out_next   <= n_out_next;
    end

endmodule

`default_nettype wire

// ----- src/brl_checker.sv -----
// Port-level checker for the byte rate limiter, bound to the top level.
// Depends on byte_rate_limiter_unit port names and brl_pkg widths.
`default_nettype none

module brl_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_in_valid,
    input wire logic                              o_in_stall,
    input wire logic                              o_out_valid,
    input wire logic                              i_out_stall,
    input wire logic [1:0]                        o_status,
    input wire logic [brl_pkg::OUT_TIME_W-1:0]    o_next_allowed_us
);

    // A waiting result stays put until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
                                       && $stable(o_next_allowed_us))
        else $error("result item changed while stalled");

    // One item at a time: once an item is taken the input side closes.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input still open right after an item was taken");

    // The input side reopens only as the item's result is presented.
    a_reopen_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_in_stall) |-> o_out_valid)
        else $error("input reopened without a result item");

    // A result appears only at the end of an item in work.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result item appeared with no item in work");

endmodule

bind byte_rate_limiter_unit brl_checker u_brl_checker (.*);

`default_nettype wire
